// ----- rtl/ipv6t_pkg.sv -----
// Shared types, character codes and helpers for the IPv6 address text formatter.
`timescale 1ns / 1ps
`default_nettype none

package ipv6t_pkg;

    localparam int ADDR_W    = 128;
    localparam int WORD_W    = 16;
    localparam int NUM_WORDS = 8;
    localparam int CHAR_W    = 7;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_OFS = 7'h57;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SCAN  = 9'b000000010,
        ST_WORD  = 9'b000000100,
        ST_SEP   = 9'b000001000,
        ST_HEX   = 9'b000010000,
        ST_TAIL  = 9'b000100000,
        ST_DCONV = 9'b001000000,
        ST_DEMIT = 9'b010000000,
        ST_DOT   = 9'b100000000
    } state_t;

    // one word presented to the zero-run scanner
    typedef struct packed {
        logic       en;
        logic       first;
        logic [2:0] idx;
        logic       zero;
        logic       ones;
    } scan_step_t;

    // chosen zero run; end_pos is base + length
    typedef struct packed {
        logic       ok;
        logic [2:0] base;
        logic [3:0] end_pos;
        logic       v4;
    } run_info_t;

    // one bit fed to the decimal converter
    typedef struct packed {
        logic en;
        logic first;
        logic bit_in;
    } dec_step_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10)
            c = CHAR_ZERO + {3'b000, nib};
        else
            c = CHAR_A_OFS + {3'b000, nib};
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ipv6_address_to_text_core.sv -----
// Top level: IPv6 address in, text characters out through a digit-serial sequencer.
//
//  channel   | dir | tdata fields (low bit up)           | tlast
//  s_axis    | in  | addr_hi[63:0], addr_lo[127:64]      | -
//  m_axis    | out | text_char[6:0], zero pad [7]        | last_char
//
// Per address the sequencer accepts it, scans the words for the longest zero run, then
// visits each word (not the last when the tail is dotted), sending characters at one per
// cycle while the output is not stalled; the run's first ':' is sent in its visit, leading
// zeros are suppressed (hex and decimal) and dotted bytes pass the bit-serial BCD converter.
// The sequencer handles one address at a time; s_axis_tready is high only when idle.
// A held output stalls any step that sends a character; reset clears all control state.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_address_to_text_core
    import ipv6t_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // addr_hi[63:0], addr_lo[127:64]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // text_char[6:0], zero [7]
    output logic              m_axis_tlast
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] words_reg, words_next;
    logic [2:0]        widx_reg, widx_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [1:0]        dpos_reg, dpos_next;
    logic [1:0]        byte_reg, byte_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    scan_step_t  scan_step;
    run_info_t   run_info;
    dec_step_t   dec_step;
    logic [9:0]  bcd;

    logic              can_emit, emit, emit_last, in_run, need;
    logic [CHAR_W-1:0] emit_char;
    logic [3:0]        nib, dig;

    ipv6t_run_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (scan_step),
        .info  (run_info)
    );

    ipv6t_dec_conv u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (dec_step),
        .bcd   (bcd)
    );

    assign can_emit = !out_valid_reg || m_axis_tready;
    assign nib      = words_reg[ADDR_W-1 -: 4];
    assign in_run   = run_info.ok && (widx_reg >= run_info.base) &&
                      ({1'b0, widx_reg} < run_info.end_pos);

    always_comb
    begin
        unique case (dpos_reg)
            2'd0:    dig = {2'b00, bcd[9:8]};
            2'd1:    dig = bcd[7:4];
            default: dig = bcd[3:0];
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        words_next   = words_reg;
        widx_next    = widx_reg;
        cnt_next     = cnt_reg;
        dpos_next    = dpos_reg;
        byte_next    = byte_reg;
        started_next = started_reg;
        emit         = 1'b0;
        emit_char    = CHAR_COLON;
        emit_last    = 1'b0;
        need         = 1'b0;

        scan_step.en    = 1'b0;
        scan_step.first = (widx_reg == 3'd0);
        scan_step.idx   = widx_reg;
        scan_step.zero  = (words_reg[ADDR_W-1 -: WORD_W] == 16'h0000);
        scan_step.ones  = (words_reg[ADDR_W-1 -: WORD_W] == 16'hffff);

        dec_step.en     = 1'b0;
        dec_step.first  = (cnt_reg == 3'd0);
        dec_step.bit_in = words_reg[ADDR_W-1];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    words_next = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                    widx_next  = 3'd0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_step.en = 1'b1;
                words_next   = {words_reg[ADDR_W-WORD_W-1:0], words_reg[ADDR_W-1 -: WORD_W]};
                widx_next    = widx_reg + 3'd1;
                if (widx_reg == 3'(NUM_WORDS - 1))
                    state_next = ST_WORD;
            end
            ST_WORD:
            begin
                cnt_next     = 3'd0;
                started_next = 1'b0;
                if (in_run)
                begin
                    // the first word of the run stands for the whole "::"
                    if (widx_reg != run_info.base || can_emit)
                    begin
                        emit       = (widx_reg == run_info.base);
                        words_next = {words_reg[ADDR_W-WORD_W-1:0],
                                      words_reg[ADDR_W-1 -: WORD_W]};
                        widx_next  = widx_reg + 3'd1;
                        if (widx_reg == 3'(NUM_WORDS - 1))
                            state_next = ST_TAIL;
                    end
                end
                else if (widx_reg != 3'd0)
                    state_next = ST_SEP;
                else
                    state_next = ST_HEX;
            end
            ST_SEP:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (widx_reg == 3'd6 && run_info.v4)
                    begin
                        byte_next  = 2'd0;
                        state_next = ST_DCONV;
                    end
                    else
                        state_next = ST_HEX;
                end
            end
            ST_HEX:
            begin
                need = (nib != 4'h0) || started_reg || (cnt_reg == 3'd3);
                if (!need || can_emit)
                begin
                    emit         = need;
                    emit_char    = hex_char(nib);
                    emit_last    = (cnt_reg == 3'd3) && (widx_reg == 3'(NUM_WORDS - 1));
                    words_next   = {words_reg[ADDR_W-5:0], nib};
                    started_next = started_reg || need;
                    cnt_next     = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_next  = 3'd0;
                        widx_next = widx_reg + 3'd1;
                        if (widx_reg == 3'(NUM_WORDS - 1))
                            state_next = ST_IDLE;
                        else
                            state_next = ST_WORD;
                    end
                end
            end
            ST_TAIL:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DCONV:
            begin
                dec_step.en = 1'b1;
                words_next  = {words_reg[ADDR_W-2:0], words_reg[ADDR_W-1]};
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    dpos_next  = 2'd0;
                    state_next = ST_DEMIT;
                end
            end
            ST_DEMIT:
            begin
                need = (dpos_reg == 2'd2) ||
                       ((dpos_reg == 2'd1) && (bcd[9:4] != 6'd0)) ||
                       ((dpos_reg == 2'd0) && (bcd[9:8] != 2'd0));
                if (!need || can_emit)
                begin
                    emit      = need;
                    emit_char = CHAR_ZERO + {3'b000, dig};
                    emit_last = (dpos_reg == 2'd2) && (byte_reg == 2'd3);
                    dpos_next = dpos_reg + 2'd1;
                    if (dpos_reg == 2'd2)
                    begin
                        if (byte_reg == 2'd3)
                            state_next = ST_IDLE;
                        else
                            state_next = ST_DOT;
                    end
                end
            end
            ST_DOT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    emit_char  = CHAR_DOT;
                    byte_next  = byte_reg + 2'd1;
                    cnt_next   = 3'd0;
                    state_next = ST_DCONV;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            widx_reg      <= '0;
            cnt_reg       <= '0;
            dpos_reg      <= '0;
            byte_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            dpos_reg      <= dpos_next;
            byte_reg      <= byte_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg    <= words_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/ipv6t_run_scan.sv -----
// Zero-run scanner: finds the longest run of zero words, one word per cycle, and flags an embedded IPv4 tail.
`timescale 1ns / 1ps
`default_nettype none

module ipv6t_run_scan
    import ipv6t_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire scan_step_t step,
    output run_info_t       info
);

    logic [2:0] cur_base_reg, cur_base_next;
    logic [3:0] cur_len_reg, cur_len_next;
    logic [2:0] best_base_reg, best_base_next;
    logic [3:0] best_len_reg, best_len_next;
    logic       w5_ones_reg, w5_ones_next;

    logic [2:0] cb, bb;
    logic [3:0] cl, bl;
    logic       w5;

    always_comb
    begin
        cb = step.first ? 3'd0 : cur_base_reg;
        cl = step.first ? 4'd0 : cur_len_reg;
        bb = step.first ? 3'd0 : best_base_reg;
        bl = step.first ? 4'd0 : best_len_reg;
        w5 = step.first ? 1'b0 : w5_ones_reg;

        cur_base_next  = cur_base_reg;
        cur_len_next   = cur_len_reg;
        best_base_next = best_base_reg;
        best_len_next  = best_len_reg;
        w5_ones_next   = w5_ones_reg;

        if (step.en)
        begin
            cur_base_next  = cb;
            best_base_next = bb;
            best_len_next  = bl;
            w5_ones_next   = (step.idx == 3'd5) ? step.ones : w5;
            if (step.zero)
            begin
                cur_len_next = cl + 4'd1;
                if (cl == 4'd0)
                    cur_base_next = step.idx;
                // strictly longer wins, so the first of equal runs stays
                if (cur_len_next > bl)
                begin
                    best_base_next = cur_base_next;
                    best_len_next  = cur_len_next;
                end
            end
            else
            begin
                cur_len_next = 4'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_base_reg  <= '0;
            cur_len_reg   <= '0;
            best_base_reg <= '0;
            best_len_reg  <= '0;
            w5_ones_reg   <= 1'b0;
        end
        else
        begin
            cur_base_reg  <= cur_base_next;
            cur_len_reg   <= cur_len_next;
            best_base_reg <= best_base_next;
            best_len_reg  <= best_len_next;
            w5_ones_reg   <= w5_ones_next;
        end
    end

    always_comb
    begin
        info.ok      = (best_len_reg >= 4'd2);
        info.base    = best_base_reg;
        info.end_pos = {1'b0, best_base_reg} + best_len_reg;
        info.v4      = (best_base_reg == 3'd0) &&
                       ((best_len_reg == 4'd6) || ((best_len_reg == 4'd5) && w5_ones_reg));
    end

endmodule

`default_nettype wire

// ----- rtl/ipv6t_dec_conv.sv -----
// Bit-serial byte to BCD converter (shift and add 3), one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ipv6t_dec_conv
    import ipv6t_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire dec_step_t  step,
    output logic [9:0]      bcd
);

    logic [9:0] bcd_reg, bcd_next;
    logic [9:0] src;
    logic [3:0] ones_adj, tens_adj;

    always_comb
    begin
        src      = step.first ? 10'd0 : bcd_reg;
        ones_adj = (src[3:0] >= 4'd5) ? src[3:0] + 4'd3 : src[3:0];
        tens_adj = (src[7:4] >= 4'd5) ? src[7:4] + 4'd3 : src[7:4];
        bcd_next = bcd_reg;
        if (step.en)
            bcd_next = {src[8], tens_adj, ones_adj, step.bit_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcd_reg <= '0;
        else
            bcd_reg <= bcd_next;
    end

    assign bcd = bcd_reg;

endmodule

`default_nettype wire

// ----- rtl/ipv6t_checker.sv -----
// Port-level checker for the IPv6 text formatter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipv6t_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [7:0]   m_axis_tdata,
    input wire logic         m_axis_tlast
);

    logic [7:0] c;
    logic       c_ok;

    assign c    = m_axis_tdata;
    assign c_ok = ((c >= 8'h30) && (c <= 8'h3a)) || (c == 8'h2e) ||
                  ((c >= 8'h61) && (c <= 8'h66));

    // held output request keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output request changed while stalled");

    // an accepted address makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a pending non-final character means the address is still in work
    a_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("idle with unfinished text");

    // only hex digits, decimal digits, colon and dot appear
    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> c_ok)
        else $error("character outside address alphabet");

endmodule

bind ipv6_address_to_text_core ipv6t_checker u_ipv6t_checker (.*);

`default_nettype wire
